@@ rtl/core/int8_affine_layer_top_assert.svh @@
// assertion macros for the int8 affine layer
`ifndef INT8_AFFINE_LAYER_TOP_ASSERT_SVH
`define INT8_AFFINE_LAYER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ rtl/core/ial_pkg.sv @@
// package with sizes, codes and types of the int8 affine layer
`timescale 1ns / 1ps
package ial_pkg;

  localparam int MAX_COLS = 512;
  localparam int MAX_ROWS = 32;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int WADDR_W = $clog2(MAX_ROWS * MAX_COLS);
  localparam int BIAS_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // usable counts, bounded by the register and out_row widths
  localparam int COL_LIM = (MAX_COLS < 1023) ? MAX_COLS : 1023;
  localparam int ROW_LIM = (MAX_ROWS < 32) ? MAX_ROWS : 32;

  // action codes
  localparam logic [1:0] ACT_WEIGHT  = 2'd0;
  localparam logic [1:0] ACT_BIAS    = 2'd1;
  localparam logic [1:0] ACT_ACT     = 2'd2;
  localparam logic [1:0] ACT_COMPUTE = 2'd3;

  // register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // position tag that travels with each column step
  typedef struct packed {
    logic       first;
    logic       last_col;
    logic       last_row;
    logic [4:0] row;
  } tag_t;

endpackage

@@ rtl/core/int8_affine_layer_top.sv @@
// quantized int8 fully connected layer: stores, sequencer and shared mac unit
`timescale 1ns / 1ps
//
// channel   dir  handshake          fields
// -------   ---  ---------          ------
// command   in   start & !busy      action row_index col_index weight_value
//                                   bias_value activation_value
// result    out  done (one cycle)   out_row row_sum is_last
// config    in   cfg_we             cfg_index cfg_data
//
// busy never rises for a load item
// during a compute, one multiply-accumulate per cycle goes through the single
// weight memory read port and the shared mac unit
// busy falls at the edge that loads the last result; done then shows it
// rst is synchronous; the stores are not cleared and hold garbage until loaded
// the result side cannot stall: each result stands for exactly one cycle
module int8_affine_layer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [4:0]         row_index,
  input  logic [8:0]         col_index,
  input  logic signed [7:0]  weight_value,
  input  logic signed [31:0] bias_value,
  input  logic [7:0]         activation_value,
  output logic               done,
  output logic [4:0]         out_row,
  output logic signed [31:0] row_sum,
  output logic               is_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [9:0]         cfg_data
);

  `include "int8_affine_layer_top_assert.svh"

  localparam int COL_W   = ial_pkg::COL_W;
  localparam int WADDR_W = ial_pkg::WADDR_W;
  localparam int BIAS_AW = ial_pkg::BIAS_AW;

  // configuration registers
  logic [9:0] cols_in_use;
  logic [5:0] rows_in_use;

  // stores
  logic [7:0]  weight_mem [ial_pkg::MAX_ROWS * ial_pkg::MAX_COLS];
  logic [31:0] bias_mem   [ial_pkg::MAX_ROWS];
  logic [7:0]  act_mem    [ial_pkg::MAX_COLS];

  // sequencer
  ial_pkg::state_t  state;
  logic [COL_W-1:0] col_cnt;
  logic [4:0]       row_cnt;
  logic [COL_W-1:0] col_last;
  logic [4:0]       row_last;

  // pipeline: read stage, multiply stage, accumulate
  logic             s1_valid;
  ial_pkg::tag_t    s1_tag;
  logic [7:0]       w_rd;
  logic [7:0]       a_rd;
  logic [31:0]      b_rd;
  logic             s2_valid;
  ial_pkg::tag_t    s2_tag;
  logic signed [16:0] prod_q;
  logic [31:0]      b2;
  logic [31:0]      acc;
  logic [31:0]      acc_next;

  logic             accept;
  logic             issue;
  logic [9:0]       ncols;
  logic [5:0]       nrows;
  logic [WADDR_W-1:0] wr_addr;
  logic [WADDR_W-1:0] rd_addr;
  logic             row_ok;
  logic             col_ok;

  assign busy   = (state != ial_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign issue  = (state == ial_pkg::ST_RUN);

  // zero counts act as one, large counts saturate
  always_comb begin
    if (cols_in_use == 10'd0) begin
      ncols = 10'd1;
    end else if (cols_in_use > 10'(ial_pkg::COL_LIM)) begin
      ncols = 10'(ial_pkg::COL_LIM);
    end else begin
      ncols = cols_in_use;
    end
    if (rows_in_use == 6'd0) begin
      nrows = 6'd1;
    end else if (rows_in_use > 6'(ial_pkg::ROW_LIM)) begin
      nrows = 6'(ial_pkg::ROW_LIM);
    end else begin
      nrows = rows_in_use;
    end
  end

  // loads outside the stores are dropped
  assign row_ok = (32'(row_index) < 32'(ial_pkg::MAX_ROWS));
  assign col_ok = (32'(col_index) < 32'(ial_pkg::MAX_COLS));

  assign wr_addr = WADDR_W'(WADDR_W'(row_index) * WADDR_W'(ial_pkg::MAX_COLS)
                   + WADDR_W'(col_index));
  assign rd_addr = WADDR_W'(WADDR_W'(row_cnt) * WADDR_W'(ial_pkg::MAX_COLS)
                   + WADDR_W'(col_cnt));

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= 10'd512;
      rows_in_use <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        ial_pkg::REG_COLS: cols_in_use <= cfg_data;
        ial_pkg::REG_ROWS: rows_in_use <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (accept && action == ial_pkg::ACT_WEIGHT && row_ok && col_ok) begin
      weight_mem[wr_addr] <= weight_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == ial_pkg::ACT_BIAS && row_ok) begin
      bias_mem[BIAS_AW'(row_index)] <= bias_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == ial_pkg::ACT_ACT && col_ok) begin
      act_mem[COL_W'(col_index)] <= activation_value;
    end
  end

  // registered store reads
  always_ff @(posedge clk) begin
    w_rd <= weight_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    a_rd <= act_mem[col_cnt];
  end

  always_ff @(posedge clk) begin
    b_rd <= bias_mem[BIAS_AW'(row_cnt)];
  end

  // sequencer: walk columns inside rows, one step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ial_pkg::ST_IDLE;
      col_cnt <= '0;
      row_cnt <= '0;
    end else begin
      case (state)
        ial_pkg::ST_IDLE: begin
          if (accept && action == ial_pkg::ACT_COMPUTE) begin
            col_cnt  <= '0;
            row_cnt  <= '0;
            col_last <= COL_W'(ncols - 10'd1);
            row_last <= 5'(nrows - 6'd1);
            state    <= ial_pkg::ST_RUN;
          end
        end
        ial_pkg::ST_RUN: begin
          if (col_cnt == col_last) begin
            col_cnt <= '0;
            if (row_cnt == row_last) begin
              state <= ial_pkg::ST_DRAIN;
            end else begin
              row_cnt <= row_cnt + 5'd1;
            end
          end else begin
            col_cnt <= col_cnt + COL_W'(1);
          end
        end
        ial_pkg::ST_DRAIN: begin
          // wait for the final row to leave the accumulator
          if (s2_valid && s2_tag.last_col && s2_tag.last_row) begin
            state <= ial_pkg::ST_IDLE;
          end
        end
        default: state <= ial_pkg::ST_IDLE;
      endcase
    end
  end

  // tags follow the reads through the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag.first    <= (col_cnt == '0);
    s1_tag.last_col <= (col_cnt == col_last);
    s1_tag.last_row <= (row_cnt == row_last);
    s1_tag.row      <= row_cnt;
    s2_tag          <= s1_tag;
    b2              <= b_rd;
    // signed weight times unsigned activation
    prod_q          <= $signed(w_rd) * $signed({1'b0, a_rd});
  end

  // shared accumulator; the first column of a row starts from the bias
  assign acc_next = (s2_tag.first ? b2 : acc) + {{15{prod_q[16]}}, prod_q};

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= acc_next;
    end
  end

  // result register, one strobe per row
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid && s2_tag.last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_tag.last_col) begin
      out_row <= s2_tag.row;
      row_sum <= acc_next;
      is_last <= s2_tag.last_row;
    end
  end

  // a compute command makes the block busy
  `ASSERT_NEXT(a_compute_busy, clk, rst, accept && action == ial_pkg::ACT_COMPUTE, busy)
  // busy only ends with the last result of a compute
  `ASSERT_IMPLY(a_fell_last, clk, rst, $fell(busy) && !$past(rst), done && is_last)
  // the last result comes with the sequencer back at rest
  `ASSERT_IMPLY(a_last_idle, clk, rst, done && is_last, state == ial_pkg::ST_IDLE)
  // no work in the pipe outside a compute
  `ASSERT_IMPLY(a_pipe_busy, clk, rst, s1_valid || s2_valid, busy)

endmodule

@@ tb/sv/int8_affine_layer_checker.sv @@
// checker for the int8 affine layer: mirrors the stores and compares each row sum
`timescale 1ns / 1ps
module int8_affine_layer_checker
  import ial_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         action,
  input  logic [4:0]         row_index,
  input  logic [8:0]         col_index,
  input  logic signed [7:0]  weight_value,
  input  logic signed [31:0] bias_value,
  input  logic [7:0]         activation_value,
  input  logic               done,
  input  logic [4:0]         out_row,
  input  logic signed [31:0] row_sum,
  input  logic               is_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [9:0]         cfg_data,
  output int                 mismatch_count,
  output int                 sums_pending,
  output int                 sums_checked,
  output int                 cols_active,
  output int                 rows_active
);

  typedef struct packed {
    logic [4:0]  row;
    logic [31:0] sum;
    logic        last;
  } row_sum_t;

  row_sum_t          expected_sums[$];
  logic signed [7:0] weight_mem [MAX_ROWS*MAX_COLS];
  logic [31:0]       bias_mem [MAX_ROWS];
  logic [7:0]        act_mem [MAX_COLS];
  int                n_cols = MAX_COLS;
  int                n_rows = ROW_LIM;
  int                errors = 0;
  int                checked = 0;
  row_sum_t          oldest;

  // zero acts as one, anything above the limit saturates
  function automatic int clamp_count(int v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // bias plus signed weight times unsigned activation, wrapping at 32 bits
  function automatic void predict_row_sums();
    logic [31:0] acc;
    int          prod;
    int          r;
    int          c;
    row_sum_t    item;
    for (r = 0; r < n_rows; r++) begin
      acc = bias_mem[r];
      for (c = 0; c < n_cols; c++) begin
        prod = int'(weight_mem[r*MAX_COLS + c]) * int'(act_mem[c]);
        acc = acc + 32'(prod);
      end
      item.row = 5'(r);
      item.sum = acc;
      item.last = (r + 1 == n_rows);
      expected_sums.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_sums.delete();
      n_cols = clamp_count(512, MAX_COLS);
      n_rows = clamp_count(32, ROW_LIM);
    end else begin
      if (done) begin
        if (expected_sums.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected row sum: row %0d sum %0d last %0d",
                     $realtime, out_row, row_sum, is_last);
        end else begin
          oldest = expected_sums.pop_front();
          checked++;
          if (out_row !== oldest.row || row_sum !== oldest.sum || is_last !== oldest.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: row sum mismatch: expected row %0d sum %0d last %0d,",
                       $realtime, oldest.row, $signed(oldest.sum), oldest.last,
                       " got row %0d sum %0d last %0d", out_row, row_sum, is_last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COLS: n_cols = clamp_count(int'(cfg_data), MAX_COLS);
          REG_ROWS: n_rows = clamp_count(int'(cfg_data[5:0]), ROW_LIM);
        endcase
      end
      if (start && !busy) begin
        case (action)
          ACT_WEIGHT:  weight_mem[int'(row_index)*MAX_COLS + int'(col_index)] = weight_value;
          ACT_BIAS:    bias_mem[row_index] = bias_value;
          ACT_ACT:     act_mem[col_index] = activation_value;
          ACT_COMPUTE: predict_row_sums();
        endcase
      end
    end
    mismatch_count <= errors;
    sums_pending   <= expected_sums.size();
    sums_checked   <= checked;
    cols_active    <= n_cols;
    rows_active    <= n_rows;
  end

endmodule

@@ tb/sv/int8_affine_layer_top_test.sv @@
// testbench top for the int8 affine layer: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module int8_affine_layer_top_test;
  import ial_pkg::*;

  localparam int ITEM_TARGET  = 230;
  // longest legal silence is a long sender gap plus a short row; far below this
  localparam int QUIET_LIMIT  = 1000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action = ACT_WEIGHT;
  logic [4:0]         row_index = '0;
  logic [8:0]         col_index = '0;
  logic signed [7:0]  weight_value = '0;
  logic signed [31:0] bias_value = '0;
  logic [7:0]         activation_value = '0;
  logic               done;
  logic [4:0]         out_row;
  logic signed [31:0] row_sum;
  logic               is_last;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_COLS;
  logic [9:0]         cfg_data = '0;

  int mismatch_count;
  int sums_pending;
  int sums_checked;
  int cols_active;
  int rows_active;

  // stimulus bookkeeping: which store entries hold a defined value
  bit weight_set [MAX_ROWS][MAX_COLS];
  bit bias_set [MAX_ROWS];
  bit act_set [MAX_COLS];
  bit no_idle = 1'b0;
  int items_sent = 0;
  int computes_sent = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  int8_affine_layer_top uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .row_index        (row_index),
    .col_index        (col_index),
    .weight_value     (weight_value),
    .bias_value       (bias_value),
    .activation_value (activation_value),
    .done             (done),
    .out_row          (out_row),
    .row_sum          (row_sum),
    .is_last          (is_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  int8_affine_layer_checker sum_check (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .row_index        (row_index),
    .col_index        (col_index),
    .weight_value     (weight_value),
    .bias_value       (bias_value),
    .activation_value (activation_value),
    .done             (done),
    .out_row          (out_row),
    .row_sum          (row_sum),
    .is_last          (is_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .sums_pending     (sums_pending),
    .sums_checked     (sums_checked),
    .cols_active      (cols_active),
    .rows_active      (rows_active)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog: any accepted item, result or register write resets the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // random field values, biased toward the extremes
  function automatic logic signed [7:0] rand_weight();
    case ($urandom_range(0, 5))
      0:       return 8'sh80;
      1:       return 8'sh7f;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_bias();
    case ($urandom_range(0, 6))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_act();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // present one item and hold it until the block takes it
  task automatic issue_item(input logic [1:0] act, input logic [4:0] r, input logic [8:0] c,
                            input logic signed [7:0] w, input logic signed [31:0] b,
                            input logic [7:0] a);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    action           <= act;
    row_index        <= r;
    col_index        <= c;
    weight_value     <= w;
    bias_value       <= b;
    activation_value <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    case (act)
      ACT_WEIGHT: weight_set[r][c] = 1'b1;
      ACT_BIAS:   bias_set[r] = 1'b1;
      ACT_ACT:    act_set[c] = 1'b1;
      default:    computes_sent++;
    endcase
  endtask

  task automatic load_any(input logic [1:0] act, input logic [4:0] r, input logic [8:0] c);
    issue_item(act, r, c, rand_weight(), rand_bias(), rand_act());
  endtask

  // stop sending and wait until every predicted row sum has come out
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0 || busy) @(posedge clk);
  endtask

  // register writes only while idle; the wait after draining lets the checker's counts settle
  task automatic write_reg(input logic idx, input logic [9:0] data);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // a compute may only read defined entries, so fill the gaps in the active window first
  task automatic prepare_and_compute();
    int r;
    int c;
    for (r = 0; r < rows_active; r++) begin
      if (!bias_set[r]) load_any(ACT_BIAS, 5'(r), 9'($urandom));
      for (c = 0; c < cols_active; c++) begin
        if (!weight_set[r][c]) load_any(ACT_WEIGHT, 5'(r), 9'(c));
      end
    end
    for (c = 0; c < cols_active; c++) begin
      if (!act_set[c]) load_any(ACT_ACT, 5'($urandom), 9'(c));
    end
    load_any(ACT_COMPUTE, 5'($urandom), 9'($urandom));
  endtask

  initial begin
    int          step;
    int          k;
    int          rows_val;
    logic [9:0]  cols_data;
    logic [9:0]  rows_data;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 2x2 matrix with extreme weights, activations and biases
    write_reg(REG_COLS, 10'd2);
    write_reg(REG_ROWS, 10'd2);
    issue_item(ACT_WEIGHT, 5'd0, 9'd0, 8'sh80, 32'sh0, 8'h00);
    issue_item(ACT_WEIGHT, 5'd0, 9'd1, 8'sh80, 32'sh0, 8'h00);
    issue_item(ACT_WEIGHT, 5'd1, 9'd0, 8'sh7f, 32'sh0, 8'h00);
    issue_item(ACT_WEIGHT, 5'd1, 9'd1, 8'sh7f, 32'sh0, 8'h00);
    issue_item(ACT_ACT, 5'd0, 9'd0, 8'sh0, 32'sh0, 8'hff);
    issue_item(ACT_ACT, 5'd0, 9'd1, 8'sh0, 32'sh0, 8'hff);
    // most negative bias pushed lower and most positive pushed higher: both wrap
    issue_item(ACT_BIAS, 5'd0, 9'd0, 8'sh0, 32'sh8000_0000, 8'h00);
    issue_item(ACT_BIAS, 5'd1, 9'd0, 8'sh0, 32'sh7fff_ffff, 8'h00);
    issue_item(ACT_COMPUTE, 5'd31, 9'd511, 8'shff, 32'shffff_ffff, 8'hff);
    // mixed signs in one row, one zero activation
    issue_item(ACT_WEIGHT, 5'd0, 9'd1, 8'sh7f, 32'sh0, 8'h00);
    issue_item(ACT_ACT, 5'd0, 9'd1, 8'sh0, 32'sh0, 8'h00);
    issue_item(ACT_COMPUTE, 5'd0, 9'd0, 8'sh0, 32'sh0, 8'h00);
    // all activations zero: bias alone
    issue_item(ACT_ACT, 5'd0, 9'd0, 8'sh0, 32'sh0, 8'h00);
    issue_item(ACT_COMPUTE, 5'd0, 9'd0, 8'sh0, 32'sh0, 8'h00);
    // zero counts act as one
    write_reg(REG_COLS, 10'd0);
    write_reg(REG_ROWS, 10'd0);
    prepare_and_compute();
    // oversized row count saturates to 32, then exactly 32, single column
    write_reg(REG_ROWS, 10'h3ff);
    prepare_and_compute();
    write_reg(REG_ROWS, 10'd32);
    prepare_and_compute();

    // random part: a new setting every 40 steps, small matrices so fills stay cheap
    for (step = 0; items_sent < ITEM_TARGET; step++) begin
      if (step % 40 == 0) begin
        k = $urandom_range(0, 9);
        if (k == 0) cols_data = 10'd0;
        else if (k == 1) cols_data = 10'($urandom_range(5, 8));
        else cols_data = 10'($urandom_range(1, 4));
        k = $urandom_range(0, 9);
        // wider rows keep the row count low so filling stays cheap
        if (cols_data > 2) rows_val = $urandom_range(1, 4);
        else if (k == 0) rows_val = 0;
        else if (k == 1) rows_val = $urandom_range(33, 63);
        else if (k == 2) rows_val = 32;
        else rows_val = $urandom_range(1, 8);
        // upper data bits are outside the row register and must not matter
        rows_data = {4'($urandom), 6'(rows_val)};
        if ($urandom_range(0, 1)) begin
          write_reg(REG_COLS, cols_data);
          write_reg(REG_ROWS, rows_data);
        end else begin
          write_reg(REG_ROWS, rows_data);
          write_reg(REG_COLS, cols_data);
        end
        no_idle = ($urandom_range(0, 3) == 0);
      end
      // occasional hold-off until the block has drained completely
      if ($urandom_range(0, 24) == 0) drain_results();
      k = $urandom_range(0, 99);
      if (k < 20) begin
        prepare_and_compute();
      end else if (k < 85) begin
        load_any(2'($urandom_range(ACT_WEIGHT, ACT_ACT)),
                 5'($urandom_range(0, rows_active - 1)),
                 9'($urandom_range(0, cols_active - 1)));
      end else begin
        // loads anywhere in the stores, outside the active window too
        load_any(2'($urandom_range(ACT_WEIGHT, ACT_ACT)), 5'($urandom), 9'($urandom));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("run covered %0d items (%0d computes), %0d register writes, %0d row sums checked",
             items_sent, computes_sent, reg_writes, sums_checked);
    $display("matrices of 1 to 32 rows and 1 to 8 columns, zero and oversized counts included");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ial_pkg.sv
rtl/core/int8_affine_layer_top.sv
tb/sv/int8_affine_layer_checker.sv
tb/sv/int8_affine_layer_top_test.sv
